// ----- rtl/irpm_pkg.sv -----
package irpm_pkg;

  // Default sizing
  localparam int MAX_PACKET_BYTES = 1024;
  localparam int MAX_PROBES       = 10;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int PPH_W    = 4;
  localparam int STATUS_W = 3;
  localparam int HOP_W    = 8;
  localparam int PROBE_W  = 4;
  localparam int ADDR_W   = 32;
  localparam int HLEN_W   = 6;
  localparam int CFG_IDX_W = 2;

  // Divider: one quotient bit per cycle over the 16-bit adjusted sequence
  localparam int DIV_STEPS = WORD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int NQ_W      = 5;

  // Protocol constants
  localparam logic [7:0] ICMP_ECHOREPLY     = 8'd0;
  localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
  localparam int IP_MIN_LEN   = 20;
  localparam int ICMP_HDR_LEN = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_ID       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBES_PER_HOP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_BASE  = 2'd2;

  // Configuration reset values
  localparam logic [WORD_W-1:0] PROBE_ID_RST       = 16'd0;
  localparam logic [PPH_W-1:0]  PROBES_PER_HOP_RST = 4'd3;
  localparam logic [WORD_W-1:0] SEQUENCE_BASE_RST  = 16'd0;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_MATCHED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRONG_TYPE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ID_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUT_WINDOW = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic take;    // byte request accepted
    logic finish;  // accepted byte was the last one
    logic step;    // one divider iteration
    logic load;    // move result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;  // current iteration is the final one
  } sts_t;

endpackage

// ----- rtl/irpm_byte_if.sv -----
interface irpm_byte_if;
  logic                          valid;
  logic                          ready;
  logic [irpm_pkg::BYTE_W-1:0]   pkt_byte;
  logic                          last;
  logic [irpm_pkg::HOP_W-1:0]    window_low;
  logic [irpm_pkg::HOP_W-1:0]    window_high;

  modport source (output valid, pkt_byte, last, window_low, window_high, input ready);
  modport sink   (input valid, pkt_byte, last, window_low, window_high, output ready);
endinterface

// ----- rtl/irpm_res_if.sv -----
interface irpm_res_if;
  logic                          valid;
  logic                          ready;
  logic [irpm_pkg::STATUS_W-1:0] status;
  logic [irpm_pkg::HOP_W-1:0]    hop;
  logic [irpm_pkg::PROBE_W-1:0]  probe;
  logic                          is_dest;
  logic [irpm_pkg::ADDR_W-1:0]   source_addr;

  modport source (output valid, status, hop, probe, is_dest, source_addr, input ready);
  modport sink   (input valid, status, hop, probe, is_dest, source_addr, output ready);
endinterface

// ----- rtl/irpm_cfg_if.sv -----
interface irpm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [irpm_pkg::CFG_IDX_W-1:0] index;
  logic [irpm_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/irpm_ctrl.sv -----
module irpm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output irpm_pkg::cmd_t     cmd,
  input  irpm_pkg::sts_t     sts
);

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state, state_next;

  // Handshake and commands
  assign in_ready   = (state == S_RUN);
  assign cmd.take   = in_valid && in_ready;
  assign cmd.finish = cmd.take && in_last;
  assign cmd.step   = (state == S_DIV);
  assign cmd.load   = (state == S_LOAD) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN:  if (cmd.finish) state_next = S_DIV;
      S_DIV:  if (sts.div_last) state_next = S_LOAD;
      S_LOAD: if (cmd.load) state_next = S_RUN;
      default: state_next = S_RUN;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/irpm_dp.sv -----
module irpm_dp #(
  parameter int MAX_PACKET_BYTES = irpm_pkg::MAX_PACKET_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  irpm_pkg::cmd_t                cmd,
  output irpm_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [irpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpm_pkg::WORD_W-1:0]   cfg_data,
  input  logic [irpm_pkg::BYTE_W-1:0]   pkt_byte,
  input  logic [irpm_pkg::HOP_W-1:0]    window_low,
  input  logic [irpm_pkg::HOP_W-1:0]    window_high,
  output logic [irpm_pkg::STATUS_W-1:0] status,
  output logic [irpm_pkg::HOP_W-1:0]    hop,
  output logic [irpm_pkg::PROBE_W-1:0]  probe,
  output logic                          is_dest,
  output logic [irpm_pkg::ADDR_W-1:0]   source_addr
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CW = (PW > 9) ? PW : 9;
  localparam int W  = irpm_pkg::WORD_W;
  localparam int HW = irpm_pkg::HLEN_W;

  // Configuration
  logic [W-1:0]               probe_id, sequence_base;
  logic [irpm_pkg::PPH_W-1:0] probes_per_hop;

  // Per-packet capture state
  logic [PW-1:0]  byte_pos;
  logic [HW-1:0]  outer_len, inner_len;
  logic [7:0]     msg_type;
  logic [W-1:0]   ident, seq;
  logic [31:0]    sender;

  // End-of-packet snapshot and divider
  logic [irpm_pkg::STATUS_W-1:0] pre_status;
  logic                          was_echo;
  logic [irpm_pkg::HOP_W-1:0]    wlo, whi;
  logic [31:0]                   src;
  logic [irpm_pkg::NQ_W-1:0]     nq;
  logic [W-1:0]                  quot;
  logic [irpm_pkg::NQ_W-1:0]     rem;
  logic [irpm_pkg::DIV_CNT_W-1:0] cnt;

  // Combinational capture
  logic           take;
  logic [CW-1:0]  pos, o_w, n_w, base;
  logic [HW-1:0]  o_cur;
  logic           hit;
  logic [PW-1:0]  pos_nxt;
  logic [HW-1:0]  outer_nxt, inner_nxt;
  logic [7:0]     msg_nxt;
  logic [W-1:0]   ident_nxt, seq_nxt;
  logic [31:0]    sender_nxt;
  logic [CW-1:0]  bytes, on_w, nn_w;
  logic [irpm_pkg::STATUS_W-1:0] pre_nxt;
  logic [irpm_pkg::NQ_W-1:0]     nq_sel;

  // Divider step
  logic [irpm_pkg::NQ_W:0] trial, trial_sub;
  logic                    ge;

  // Result
  logic [W:0] hop_full;

  // Field capture for the current byte
  always_comb begin
    take  = (byte_pos < PW'(MAX_PACKET_BYTES));
    pos   = CW'(byte_pos);
    o_cur = (byte_pos == '0) ? {pkt_byte[3:0], 2'b00} : outer_len;
    o_w   = CW'(o_cur);
    n_w   = o_w + CW'(irpm_pkg::ICMP_HDR_LEN);
    hit   = 1'b0;
    base  = o_w;
    if (msg_type == irpm_pkg::ICMP_ECHOREPLY && pos > o_w) begin
      hit  = 1'b1;
      base = o_w;
    end else if (msg_type == irpm_pkg::ICMP_TIME_EXCEEDED && pos > n_w) begin
      hit  = 1'b1;
      base = n_w + CW'(inner_len);
    end

    pos_nxt   = take ? byte_pos + PW'(1) : byte_pos;
    outer_nxt = take ? o_cur : outer_len;
    msg_nxt   = (take && pos == o_w) ? pkt_byte : msg_type;
    inner_nxt = (take && msg_type == irpm_pkg::ICMP_TIME_EXCEEDED && pos == n_w)
                ? {pkt_byte[3:0], 2'b00} : inner_len;
    ident_nxt = (take && hit && (pos == base + CW'(4) || pos == base + CW'(5)))
                ? {ident[7:0], pkt_byte} : ident;
    seq_nxt   = (take && hit && (pos == base + CW'(6) || pos == base + CW'(7)))
                ? {seq[7:0], pkt_byte} : seq;
    sender_nxt = (take && pos >= CW'(12) && pos <= CW'(15))
                 ? {sender[23:0], pkt_byte} : sender;
  end

  // Classification before the hop window check
  always_comb begin
    bytes = CW'(pos_nxt);
    on_w  = CW'(outer_nxt);
    nn_w  = on_w + CW'(irpm_pkg::ICMP_HDR_LEN);
    if (bytes < CW'(irpm_pkg::IP_MIN_LEN) || bytes < nn_w) begin
      pre_nxt = irpm_pkg::ST_TRUNCATED;
    end else if (msg_nxt == irpm_pkg::ICMP_ECHOREPLY) begin
      pre_nxt = (ident_nxt != probe_id) ? irpm_pkg::ST_ID_MISMATCH : irpm_pkg::ST_MATCHED;
    end else if (msg_nxt == irpm_pkg::ICMP_TIME_EXCEEDED) begin
      if (bytes < nn_w + CW'(irpm_pkg::IP_MIN_LEN) ||
          bytes < nn_w + CW'(inner_nxt) + CW'(irpm_pkg::ICMP_HDR_LEN))
        pre_nxt = irpm_pkg::ST_TRUNCATED;
      else
        pre_nxt = (ident_nxt != probe_id) ? irpm_pkg::ST_ID_MISMATCH : irpm_pkg::ST_MATCHED;
    end else begin
      pre_nxt = irpm_pkg::ST_WRONG_TYPE;
    end
  end

  // Divisor clamp
  always_comb begin
    if (probes_per_hop == '0)
      nq_sel = irpm_pkg::NQ_W'(1);
    else if (irpm_pkg::NQ_W'(probes_per_hop) > irpm_pkg::NQ_W'(irpm_pkg::MAX_PROBES))
      nq_sel = irpm_pkg::NQ_W'(irpm_pkg::MAX_PROBES);
    else
      nq_sel = irpm_pkg::NQ_W'(probes_per_hop);
  end

  // Restoring divider step
  always_comb begin
    trial     = {rem, quot[W-1]};
    ge        = (trial >= {1'b0, nq});
    trial_sub = trial - {1'b0, nq};
  end

  assign sts.div_last = (cnt == irpm_pkg::DIV_CNT_W'(irpm_pkg::DIV_STEPS - 1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_id       <= irpm_pkg::PROBE_ID_RST;
      probes_per_hop <= irpm_pkg::PROBES_PER_HOP_RST;
      sequence_base  <= irpm_pkg::SEQUENCE_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irpm_pkg::REG_PROBE_ID:       probe_id       <= cfg_data;
        irpm_pkg::REG_PROBES_PER_HOP: probes_per_hop <= cfg_data[irpm_pkg::PPH_W-1:0];
        irpm_pkg::REG_SEQUENCE_BASE:  sequence_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture state, cleared after every last byte
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      byte_pos  <= '0;
      outer_len <= '0;
      inner_len <= '0;
      msg_type  <= '0;
      ident     <= '0;
      seq       <= '0;
      sender    <= '0;
    end else if (cmd.take) begin
      byte_pos  <= pos_nxt;
      outer_len <= outer_nxt;
      inner_len <= inner_nxt;
      msg_type  <= msg_nxt;
      ident     <= ident_nxt;
      seq       <= seq_nxt;
      sender    <= sender_nxt;
    end
  end

  // Snapshot at the last byte, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pre_status <= pre_nxt;
      was_echo   <= (msg_nxt == irpm_pkg::ICMP_ECHOREPLY);
      wlo        <= window_low;
      whi        <= window_high;
      src        <= sender_nxt;
      nq         <= nq_sel;
      quot       <= seq_nxt - sequence_base;
      rem        <= '0;
      cnt        <= '0;
    end else if (cmd.step) begin
      quot <= {quot[W-2:0], ge};
      rem  <= ge ? trial_sub[irpm_pkg::NQ_W-1:0] : trial[irpm_pkg::NQ_W-1:0];
      cnt  <= cnt + irpm_pkg::DIV_CNT_W'(1);
    end
  end

  // Window check and output register
  assign hop_full = {1'b0, quot} + (W+1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      source_addr <= src;
      if (pre_status != irpm_pkg::ST_MATCHED) begin
        status  <= pre_status;
        hop     <= '0;
        probe   <= '0;
        is_dest <= 1'b0;
      end else if (hop_full < (W+1)'(wlo) || hop_full > (W+1)'(whi)) begin
        status  <= irpm_pkg::ST_OUT_WINDOW;
        hop     <= '0;
        probe   <= '0;
        is_dest <= 1'b0;
      end else begin
        status  <= irpm_pkg::ST_MATCHED;
        hop     <= hop_full[irpm_pkg::HOP_W-1:0];
        probe   <= rem[irpm_pkg::PROBE_W-1:0];
        is_dest <= was_echo;
      end
    end
  end

endmodule

// ----- rtl/icmp_reply_probe_matcher.sv -----
// Packet bytes are taken at one per cycle until the byte marked last.
// After the last byte the input stalls while the bit-serial divider runs
// (one quotient bit per cycle) and until the result is placed in the output
// register, which waits while an earlier result is still held unaccepted.
// Synchronous active-high reset clears the capture state and output valid
// and returns the configuration registers to their reset values.
module icmp_reply_probe_matcher #(
  parameter int MAX_PACKET_BYTES = irpm_pkg::MAX_PACKET_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  irpm_byte_if.sink   rx,
  irpm_res_if.source  res,
  irpm_cfg_if.sink    cfg
);

  irpm_pkg::cmd_t cmd;
  irpm_pkg::sts_t sts;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  irpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_last   (rx.last),
    .in_ready  (rx.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  irpm_dp #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .pkt_byte    (rx.pkt_byte),
    .window_low  (rx.window_low),
    .window_high (rx.window_high),
    .status      (res.status),
    .hop         (res.hop),
    .probe       (res.probe),
    .is_dest     (res.is_dest),
    .source_addr (res.source_addr)
  );

endmodule

// ----- rtl/irpm_checker.sv -----
module irpm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [irpm_pkg::STATUS_W-1:0] status,
  input logic [irpm_pkg::HOP_W-1:0]    hop,
  input logic [irpm_pkg::PROBE_W-1:0]  probe,
  input logic                          is_dest,
  input logic [irpm_pkg::ADDR_W-1:0]   source_addr
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(hop) &&
                                $stable(probe) && $stable(is_dest) && $stable(source_addr))
    else $error("result changed while stalled");

  // Only a match carries hop, probe and destination flag
  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != irpm_pkg::ST_MATCHED |-> hop == '0 && probe == '0 && !is_dest)
    else $error("unmatched result carries hop data");

  // A matched hop lies inside a window of byte-wide hop numbers, never zero
  a_match_hop: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == irpm_pkg::ST_MATCHED |-> hop != '0)
    else $error("matched result with zero hop");

  // The input stalls while the end-of-packet division runs
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("byte request taken during division");

endmodule

bind icmp_reply_probe_matcher irpm_checker u_irpm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (rx.valid),
  .in_ready    (rx.ready),
  .in_last     (rx.last),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .status      (res.status),
  .hop         (res.hop),
  .probe       (res.probe),
  .is_dest     (res.is_dest),
  .source_addr (res.source_addr)
);

// ----- tb/tb_top.sv -----
module tb_top;
  import irpm_pkg::*;

  // Spare register slot: writes there must leave every setting untouched
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 24;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HOP_W-1:0]    hop;
    logic [PROBE_W-1:0]  probe;
    logic                is_dest;
    logic [ADDR_W-1:0]   source_addr;
  } verdict_t;

  // One packet to send: header fields placed over random filler
  typedef struct packed {
    logic [7:0]  msg;
    logic [3:0]  ihl;
    logic [3:0]  in_ihl;
    logic [11:0] len;
    logic [15:0] ident;
    logic [15:0] seq;
    logic [31:0] src;
    logic [7:0]  wlo;
    logic [7:0]  whi;
    logic        fixed;
    verdict_t    v;
  } frame_spec_t;

  typedef struct packed {
    logic     fixed;
    verdict_t v;
  } frame_note_t;

  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] pph;
    logic [15:0] base;
    logic [1:0]  mode;
  } setting_t;

  localparam verdict_t    NO_VERDICT = '0;
  localparam logic [31:0] HOST_A     = 32'hC0A80001;
  localparam logic [31:0] HOST_B     = 32'h0A000001;

  logic clk = 1'b0;
  logic rst;

  irpm_byte_if rx_if();
  irpm_res_if  res_if();
  irpm_cfg_if  cfg_if();

  icmp_reply_probe_matcher uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Directed packets; the verdict is typed in only where it is obvious
  frame_spec_t directed_rows [21] = '{
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd28, 16'h0000, 16'h0000, HOST_A, 8'd1, 8'd1,
      1'b1, '{ST_MATCHED, 8'd1, 4'd0, 1'b1, HOST_A}},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd1, 16'h0000, 16'h0000, HOST_A, 8'd1, 8'd255,
      1'b1, '{ST_TRUNCATED, 8'd0, 4'd0, 1'b0, 32'h0}},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd19, 16'h0000, 16'h0000, HOST_B, 8'd1, 8'd255,
      1'b1, '{ST_TRUNCATED, 8'd0, 4'd0, 1'b0, HOST_B}},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd27, 16'h0000, 16'h0000, 32'hFFFFFFFF, 8'd1, 8'd255,
      1'b1, '{ST_TRUNCATED, 8'd0, 4'd0, 1'b0, 32'hFFFFFFFF}},
    '{8'd3, 4'd5, 4'd5, 12'd28, 16'h0000, 16'h0000, HOST_A, 8'd1, 8'd255,
      1'b1, '{ST_WRONG_TYPE, 8'd0, 4'd0, 1'b0, HOST_A}},
    '{8'hFF, 4'd5, 4'd5, 12'd28, 16'h0000, 16'h0000, 32'h0, 8'd1, 8'd255,
      1'b1, '{ST_WRONG_TYPE, 8'd0, 4'd0, 1'b0, 32'h0}},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd28, 16'hFFFF, 16'h0000, HOST_B, 8'd1, 8'd255,
      1'b1, '{ST_ID_MISMATCH, 8'd0, 4'd0, 1'b0, HOST_B}},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd28, 16'h0000, 16'hFFFF, HOST_A, 8'd1, 8'd255,
      1'b1, '{ST_OUT_WINDOW, 8'd0, 4'd0, 1'b0, HOST_A}},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd28, 16'h0000, 16'h0000, HOST_A, 8'd2, 8'd255,
      1'b1, '{ST_OUT_WINDOW, 8'd0, 4'd0, 1'b0, HOST_A}},
    '{ICMP_TIME_EXCEEDED, 4'd5, 4'd5, 12'd47, 16'h0000, 16'h0000, HOST_B, 8'd1, 8'd255,
      1'b1, '{ST_TRUNCATED, 8'd0, 4'd0, 1'b0, HOST_B}},
    '{ICMP_TIME_EXCEEDED, 4'd5, 4'd15, 12'd95, 16'h0000, 16'h0000, HOST_A, 8'd1, 8'd255,
      1'b1, '{ST_TRUNCATED, 8'd0, 4'd0, 1'b0, HOST_A}},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd28, 16'h0000, 16'd5, HOST_B, 8'd1, 8'd255,
      1'b0, NO_VERDICT},
    '{ICMP_TIME_EXCEEDED, 4'd5, 4'd5, 12'd56, 16'h0000, 16'd7, HOST_A, 8'd1, 8'd255,
      1'b0, NO_VERDICT},
    '{ICMP_TIME_EXCEEDED, 4'd15, 4'd15, 12'd136, 16'h0000, 16'd2, HOST_B, 8'd1, 8'd1,
      1'b0, NO_VERDICT},
    '{ICMP_ECHOREPLY, 4'd0, 4'd5, 12'd28, 16'h0000, 16'd1, HOST_A, 8'd1, 8'd255,
      1'b0, NO_VERDICT},
    '{ICMP_ECHOREPLY, 4'd3, 4'd5, 12'd28, 16'h0000, 16'd3, HOST_B, 8'd1, 8'd255,
      1'b0, NO_VERDICT},
    '{ICMP_TIME_EXCEEDED, 4'd4, 4'd2, 12'd40, 16'h0000, 16'd4, HOST_A, 8'd1, 8'd255,
      1'b0, NO_VERDICT},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd1100, 16'h0000, 16'd4, HOST_B, 8'd1, 8'd255,
      1'b0, NO_VERDICT},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd28, 16'h0000, 16'd764, HOST_A, 8'd255, 8'd255,
      1'b0, NO_VERDICT},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd28, 16'h0000, 16'd765, HOST_B, 8'd1, 8'd255,
      1'b0, NO_VERDICT},
    '{ICMP_ECHOREPLY, 4'd5, 4'd5, 12'd28, 16'h0000, 16'd0, HOST_A, 8'd200, 8'd100,
      1'b0, NO_VERDICT}
  };

  // Register settings per random phase, extremes included
  setting_t settings [8] = '{
    '{16'h1234, 16'd3,    16'h0000, 2'(IDLE_NONE)},
    '{16'hFFFF, 16'd1,    16'hFFFF, 2'(IDLE_SEND)},
    '{16'h0000, 16'd10,   16'h8000, 2'(IDLE_RECV)},
    '{16'hA5C3, 16'd0,    16'h0001, 2'(IDLE_BOTH)},
    '{16'h5A3C, 16'hFFFF, 16'hFFF0, 2'(IDLE_NONE)},
    '{16'h7E81, 16'hFFF7, 16'h0100, 2'(IDLE_SEND)},
    '{16'h8001, 16'd2,    16'h7FFF, 2'(IDLE_RECV)},
    '{16'h3C5A, 16'd5,    16'hC000, 2'(IDLE_BOTH)}
  };

  // Register copies and per-packet capture state
  logic [15:0] id_reg;
  logic [3:0]  pph_reg;
  logic [15:0] base_reg;
  int unsigned cur_pos;
  int unsigned outer_len;
  int unsigned inner_len;
  logic [7:0]  msg_kind;
  logic [15:0] ident_acc;
  logic [15:0] seq_acc;
  logic [31:0] src_acc;

  verdict_t    pending_verdicts [$];
  frame_note_t frame_notes [$];
  logic [7:0]  frame [$];

  verdict_t    got_want;
  verdict_t    got_pred;
  frame_note_t got_note;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  function automatic int unsigned eff_probes();
    if (pph_reg == 4'd0)
      return 1;
    if (pph_reg > MAX_PROBES)
      return MAX_PROBES;
    return pph_reg;
  endfunction

  function void clear_frame_state();
    cur_pos   = 0;
    outer_len = 0;
    inner_len = 0;
    msg_kind  = '0;
    ident_acc = '0;
    seq_acc   = '0;
    src_acc   = '0;
  endfunction

  function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    case (idx)
      REG_PROBE_ID:       id_reg   = data;
      REG_PROBES_PER_HOP: pph_reg  = data[3:0];
      REG_SEQUENCE_BASE:  base_reg = data;
      default: ;
    endcase
  endfunction

  // Echo id sits at offset 4..5 and sequence at 6..7 of an ICMP header
  function void grab_echo(int unsigned pos, int unsigned hdr, logic [7:0] b);
    if (pos == hdr + 4 || pos == hdr + 5)
      ident_acc = {ident_acc[7:0], b};
    if (pos == hdr + 6 || pos == hdr + 7)
      seq_acc = {seq_acc[7:0], b};
  endfunction

  function void track_reply_byte(logic [7:0] b);
    int unsigned o;
    int unsigned n;
    if (cur_pos < MAX_PACKET_BYTES) begin
      if (cur_pos == 0)
        outer_len = {b[3:0], 2'b00};
      o = outer_len;
      if (cur_pos >= 12 && cur_pos <= 15)
        src_acc = {src_acc[23:0], b};
      if (cur_pos == o)
        msg_kind = b;
      if (cur_pos > o && msg_kind == ICMP_ECHOREPLY)
        grab_echo(cur_pos, o, b);
      if (cur_pos > o && msg_kind == ICMP_TIME_EXCEEDED) begin
        n = o + ICMP_HDR_LEN;
        if (cur_pos == n)
          inner_len = {b[3:0], 2'b00};
        if (cur_pos > n)
          grab_echo(cur_pos, n + inner_len, b);
      end
      cur_pos++;
    end
  endfunction

  // Classify the finished packet and map its sequence to hop and probe
  function verdict_t close_frame(logic [7:0] wlo, logic [7:0] whi);
    int unsigned n;
    int unsigned nq;
    int unsigned adj;
    int unsigned hop_n;
    logic [15:0] diff;
    verdict_t    v;
    v = NO_VERDICT;
    v.source_addr = src_acc;
    n = outer_len + ICMP_HDR_LEN;
    if (cur_pos < IP_MIN_LEN || cur_pos < n)
      v.status = ST_TRUNCATED;
    else if (msg_kind == ICMP_ECHOREPLY)
      v.status = (ident_acc != id_reg) ? ST_ID_MISMATCH : ST_MATCHED;
    else if (msg_kind == ICMP_TIME_EXCEEDED) begin
      if (cur_pos < n + IP_MIN_LEN || cur_pos < n + inner_len + ICMP_HDR_LEN)
        v.status = ST_TRUNCATED;
      else
        v.status = (ident_acc != id_reg) ? ST_ID_MISMATCH : ST_MATCHED;
    end else
      v.status = ST_WRONG_TYPE;
    if (v.status == ST_MATCHED) begin
      nq    = eff_probes();
      diff  = seq_acc - base_reg;
      adj   = diff;
      hop_n = adj / nq + 1;
      if (hop_n < wlo || hop_n > whi)
        v.status = ST_OUT_WINDOW;
      else begin
        v.hop     = hop_n[7:0];
        v.probe   = 4'(adj % nq);
        v.is_dest = (msg_kind == ICMP_ECHOREPLY);
      end
    end
    clear_frame_state();
    return v;
  endfunction

  function void place(int unsigned at, logic [7:0] b);
    if (at < frame.size())
      frame[at] = b;
  endfunction

  // Lay the header fields of a spec over random bytes
  function void build_frame(frame_spec_t s);
    int unsigned o;
    int unsigned e;
    frame.delete();
    for (int i = 0; i < s.len; i++)
      frame.push_back(8'($urandom));
    place(0, {4'h4, s.ihl});
    for (int k = 0; k < 4; k++)
      place(12 + k, s.src[31 - 8 * k -: 8]);
    o = {s.ihl, 2'b00};
    place(o, s.msg);
    e = o;
    if (s.msg == ICMP_TIME_EXCEEDED) begin
      place(o + ICMP_HDR_LEN, {4'h4, s.in_ihl});
      e = o + ICMP_HDR_LEN + {s.in_ihl, 2'b00};
    end
    place(e + 4, s.ident[15:8]);
    place(e + 5, s.ident[7:0]);
    place(e + 6, s.seq[15:8]);
    place(e + 7, s.seq[7:0]);
  endfunction

  // Mostly well-formed replies near the current window, some broken or noise
  function automatic frame_spec_t random_spec();
    frame_spec_t s;
    int unsigned pick;
    int unsigned nq;
    int unsigned off;
    int unsigned hop_n;
    int unsigned full;
    s      = '0;
    pick   = $urandom_range(99);
    nq     = eff_probes();
    s.src  = $urandom;
    s.ihl  = ($urandom_range(4) == 0) ? 4'($urandom_range(8, 5)) : 4'd5;
    s.in_ihl = ($urandom_range(4) == 0) ? 4'($urandom_range(8, 5)) : 4'd5;
    s.ident = ($urandom_range(9) < 8) ? id_reg : 16'($urandom);
    off    = $urandom_range(nq * 8 - 1);
    s.seq  = base_reg + 16'(off);
    if ($urandom_range(9) == 0)
      s.seq = 16'($urandom);
    hop_n  = off / nq + 1;
    if ($urandom_range(3) == 0) begin
      s.wlo = 8'($urandom_range(255, 1));
      s.whi = 8'($urandom_range(255, 1));
    end else begin
      s.wlo = 8'($urandom_range(hop_n, 1));
      s.whi = 8'($urandom_range(hop_n + 12, hop_n));
    end
    if (pick < 45) begin
      s.msg = ICMP_ECHOREPLY;
      full  = s.ihl * 4 + ICMP_HDR_LEN;
    end else if (pick < 80) begin
      s.msg = ICMP_TIME_EXCEEDED;
      full  = s.ihl * 4 + 2 * ICMP_HDR_LEN + s.in_ihl * 4;
    end else begin
      s.ihl    = 4'($urandom);
      s.in_ihl = 4'($urandom);
      case ($urandom_range(2))
        0:       s.msg = ICMP_ECHOREPLY;
        1:       s.msg = ICMP_TIME_EXCEEDED;
        default: s.msg = 8'($urandom);
      endcase
      full = $urandom_range(90, 1);
    end
    s.len = 12'(full + $urandom_range(4));
    if (pick < 80 && $urandom_range(9) == 0)
      s.len = 12'($urandom_range(full - 1, 1));
    return s;
  endfunction

  task automatic set_idle(idle_mode_e m);
    case (m)
      IDLE_SEND: begin send_idle_pct = 85; stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 85; end
      IDLE_BOTH: begin send_idle_pct = 18; stall_pct = 18; end
      default:   begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic send_frame(logic [7:0] wlo, logic [7:0] whi);
    for (int i = 0; i < frame.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        rx_if.valid <= 1'b0;
        @(negedge clk);
      end
      rx_if.valid    <= 1'b1;
      rx_if.pkt_byte <= frame[i];
      rx_if.last     <= (i == frame.size() - 1);
      if (i == frame.size() - 1) begin
        rx_if.window_low  <= wlo;
        rx_if.window_high <= whi;
      end else begin
        rx_if.window_low  <= 8'($urandom_range(255, 1));
        rx_if.window_high <= 8'($urandom_range(255, 1));
      end
      do @(posedge clk); while (!rx_if.ready);
      @(negedge clk);
    end
  endtask

  task automatic send_spec(frame_spec_t s);
    build_frame(s);
    frame_notes.push_back('{s.fixed, s.v});
    send_frame(s.wlo, s.whi);
  endtask

  // Let every outstanding result drain and the divider go quiet
  task automatic settle();
    while (pending_verdicts.size() != 0 || frame_notes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Prediction on accepted requests and checking of accepted results
  always @(posedge clk) begin
    if (rst) begin
      id_reg   = PROBE_ID_RST;
      pph_reg  = PROBES_PER_HOP_RST;
      base_reg = SEQUENCE_BASE_RST;
      clear_frame_state();
    end else begin
      if (cfg_if.valid && cfg_if.ready)
        apply_reg(cfg_if.index, cfg_if.data);
      if (rx_if.valid && rx_if.ready) begin
        track_reply_byte(rx_if.pkt_byte);
        if (rx_if.last) begin
          got_pred = close_frame(rx_if.window_low, rx_if.window_high);
          got_note = frame_notes.pop_front();
          pending_verdicts.push_back(got_note.fixed ? got_note.v : got_pred);
        end
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result with none pending: status %0d source_addr %h",
                 res_if.status, res_if.source_addr);
          mismatches++;
        end else begin
          got_want = pending_verdicts.pop_front();
          if (res_if.status !== got_want.status) begin
            $error("status: expected %0d, got %0d", got_want.status, res_if.status);
            mismatches++;
          end
          if (res_if.hop !== got_want.hop) begin
            $error("hop: expected %0d, got %0d", got_want.hop, res_if.hop);
            mismatches++;
          end
          if (res_if.probe !== got_want.probe) begin
            $error("probe: expected %0d, got %0d", got_want.probe, res_if.probe);
            mismatches++;
          end
          if (res_if.is_dest !== got_want.is_dest) begin
            $error("is_dest: expected %0d, got %0d", got_want.is_dest, res_if.is_dest);
            mismatches++;
          end
          if (res_if.source_addr !== got_want.source_addr) begin
            $error("source_addr: expected %h, got %h",
                   got_want.source_addr, res_if.source_addr);
            mismatches++;
          end
        end
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("icmp_reply_probe_matcher regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed packets on reset settings, then random phases
  initial begin
    int unsigned phase_bytes;
    int unsigned phase_frames;
    frame_spec_t s;
    mismatches        = 0;
    quiet_cycles      = 0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    rst               = 1'b1;
    rx_if.valid       = 1'b0;
    rx_if.pkt_byte    = '0;
    rx_if.last        = 1'b0;
    rx_if.window_low  = 8'd1;
    rx_if.window_high = 8'd1;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idle(IDLE_NONE);
    foreach (directed_rows[r])
      send_spec(directed_rows[r]);
    rx_if.valid <= 1'b0;

    foreach (settings[p]) begin
      settle();
      if (p == 0)
        write_reg(REG_SPARE, 16'($urandom));
      write_reg(REG_PROBE_ID, settings[p].ident);
      write_reg(REG_PROBES_PER_HOP, settings[p].pph);
      write_reg(REG_SEQUENCE_BASE, settings[p].base);
      cfg_if.valid <= 1'b0;
      set_idle(idle_mode_e'(settings[p].mode));
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < 70 || phase_frames < 8) begin
        s = random_spec();
        send_spec(s);
        phase_bytes  += s.len;
        phase_frames += 1;
      end
      rx_if.valid <= 1'b0;
    end

    settle();
    if (mismatches == 0)
      $display("icmp_reply_probe_matcher regression: pass");
    else
      $display("icmp_reply_probe_matcher regression: fail");
    $finish;
  end

endmodule
